>>> rtl/rvna_pkg.sv
// Package for the route vector nibble ALU.
// Holds the operation codes, field widths and the request word type.
// No dependencies.
`timescale 1ns / 1ps

package rvna_pkg;

  localparam int VEC_W = 64;
  localparam int HOP_W = 4;
  localparam int HOP_CNT = 16;
  localparam int OP_W = 3;
  localparam int IDX_W = 5;
  localparam int LEN_W = 5;
  localparam int POS_W = 4;
  localparam int SH_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_LENGTH  = 3'd0,
    OP_GET     = 3'd1,
    OP_PREFIX  = 3'd2,
    OP_MODIFY  = 3'd3,
    OP_REVERSE = 3'd4,
    OP_CONCAT  = 3'd5
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [VEC_W-1:0] vec_a;
    logic [VEC_W-1:0] vec_b;
    logic [IDX_W-1:0] nibble_index;
    logic [HOP_W-1:0] route_nibble;
  } rvna_req_t;

endpackage

>>> rtl/rvna_core.sv
// Combinational datapath of the route vector nibble ALU.
// Computes one result word from one registered request word.
// Depends on rvna_pkg.
`timescale 1ns / 1ps

module rvna_core (
  input  rvna_pkg::rvna_req_t       req,
  output logic [rvna_pkg::VEC_W-1:0] result_value
);
  import rvna_pkg::*;

  logic [HOP_CNT-1:0] nz;
  logic [LEN_W-1:0]   len;
  logic [POS_W-1:0]   hi;
  logic               any_nz;
  logic [VEC_W-1:0]   rev_full;
  logic [SH_W-1:0]    idx_sh;
  logic [SH_W-1:0]    len_sh;
  logic [SH_W-1:0]    rev_sh;
  logic [VEC_W-1:0]   v_get;
  logic [VEC_W-1:0]   v_prefix;
  logic [VEC_W-1:0]   v_modify;
  logic [VEC_W-1:0]   v_reverse;
  logic [VEC_W-1:0]   v_concat;

  always_comb begin
    for (int i = 0; i < HOP_CNT; i++) begin
      nz[i] = |req.vec_a[i*HOP_W +: HOP_W];
      rev_full[i*HOP_W +: HOP_W] = req.vec_a[(HOP_CNT-1-i)*HOP_W +: HOP_W];
    end
  end

  always_comb begin
    len = LEN_W'(HOP_CNT);
    for (int i = HOP_CNT - 1; i >= 0; i--) begin
      if (!nz[i]) begin
        len = LEN_W'(i);
      end
    end
  end

  always_comb begin
    hi = '0;
    for (int i = 0; i < HOP_CNT; i++) begin
      if (nz[i]) begin
        hi = POS_W'(i);
      end
    end
  end

  assign any_nz = |nz;
  assign idx_sh = {req.nibble_index[POS_W-1:0], 2'b00};
  assign len_sh = {len[POS_W-1:0], 2'b00};
  assign rev_sh = {~hi, 2'b00};

  assign v_get = req.nibble_index[IDX_W-1] ? '0 :
                 ((req.vec_a >> idx_sh) & VEC_W'({HOP_W{1'b1}}));

  always_comb begin
    if (req.nibble_index == '0) begin
      v_prefix = '0;
    end else if (req.nibble_index[IDX_W-1]) begin
      v_prefix = req.vec_a;
    end else begin
      v_prefix = req.vec_a & ~({VEC_W{1'b1}} << idx_sh);
    end
  end

  assign v_modify = req.nibble_index[IDX_W-1] ? req.vec_a :
                    ((req.vec_a & ~(VEC_W'({HOP_W{1'b1}}) << idx_sh)) |
                     (VEC_W'(req.route_nibble) << idx_sh));

  assign v_reverse = any_nz ? (rev_full >> rev_sh) : '0;

  assign v_concat = len[LEN_W-1] ? req.vec_a : (req.vec_a | (req.vec_b << len_sh));

  always_comb begin
    case (op_t'(req.operation))
      OP_LENGTH:  result_value = VEC_W'(len);
      OP_GET:     result_value = v_get;
      OP_PREFIX:  result_value = v_prefix;
      OP_MODIFY:  result_value = v_modify;
      OP_REVERSE: result_value = v_reverse;
      OP_CONCAT:  result_value = v_concat;
      default:    result_value = '0;
    endcase
  end

endmodule

>>> rtl/route_vector_nibble_alu.sv
// Top level of the route vector nibble ALU.
// Input register, rvna_core datapath and output register.
// Depends on rvna_pkg and rvna_core.
//
// Usage:
//   Input channel: in_valid / in_stall with in_operation, in_vec_a, in_vec_b,
//   in_nibble_index and in_route_nibble. A word is taken at a rising edge with
//   in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with out_result_value, one result
//   word for every input word, in order.
//   Path: an accepted word goes to the input register, then the result register
//   drives out_valid. Throughput: one word per cycle while out_stall is low, set
//   by the single registered pass through the datapath.
//   Stall: while out_stall holds a result, the input register still takes one
//   more word; in_stall rises only when both registers are full and the
//   receiver stalls. A stalled result holds unchanged.
//   Reset: rst_n low at a clock edge empties both registers; no word is shown
//   afterward until new input arrives.
`timescale 1ns / 1ps

module route_vector_nibble_alu (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rvna_pkg::OP_W-1:0]    in_operation,
  input  logic [rvna_pkg::VEC_W-1:0]   in_vec_a,
  input  logic [rvna_pkg::VEC_W-1:0]   in_vec_b,
  input  logic [rvna_pkg::IDX_W-1:0]   in_nibble_index,
  input  logic [rvna_pkg::HOP_W-1:0]   in_route_nibble,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rvna_pkg::VEC_W-1:0]   out_result_value
);
  import rvna_pkg::*;

  rvna_req_t        req_r;
  logic             req_valid_r;
  logic             req_valid_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [VEC_W-1:0] result_r;
  logic [VEC_W-1:0] result_nxt;
  logic             in_load;
  logic             out_load;

  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = req_valid_r && !out_load;
  assign in_load  = in_valid && !in_stall;

  always_comb begin
    if (in_load) begin
      req_valid_nxt = 1'b1;
    end else if (out_load) begin
      req_valid_nxt = 1'b0;
    end else begin
      req_valid_nxt = req_valid_r;
    end
    out_valid_nxt = out_load ? req_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      req_r.operation    <= in_operation;
      req_r.vec_a        <= in_vec_a;
      req_r.vec_b        <= in_vec_b;
      req_r.nibble_index <= in_nibble_index;
      req_r.route_nibble <= in_route_nibble;
    end
    if (out_load && req_valid_r) begin
      result_r <= result_nxt;
    end
  end

  rvna_core u_core (
    .req          (req_r),
    .result_value (result_nxt)
  );

  assign out_valid        = out_valid_r;
  assign out_result_value = result_r;

endmodule

>>> rtl/rvna_chk.sv
// Port checker for the route vector nibble ALU, bound to the top level.
// Watches handshakes and latency on the top-level ports only.
// Depends on rvna_pkg and route_vector_nibble_alu.
`timescale 1ns / 1ps

module rvna_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [rvna_pkg::VEC_W-1:0]   out_result_value
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted word missing two cycles later");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_result_value))
    else $error("stalled result changed");

endmodule

bind route_vector_nibble_alu rvna_chk u_rvna_chk (.*);
